// ===== hw/rtl/half_duplex_frame_timeout_ctrl_top_macros.svh =====
// ----------------------------------------------------------------------------
// Half-duplex frame timeout controller assertion macros
// Property wrappers used by the core's checks; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_FRAME_TIMEOUT_CTRL_TOP_MACROS_SVH
`define HALF_DUPLEX_FRAME_TIMEOUT_CTRL_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define HDFTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hdftc check failed");

// Next-cycle implication, disabled during reset.
`define HDFTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hdftc check failed");

`else

`define HDFTC_ASSERT_NOW(label, clk, rst, ante, cons)
`define HDFTC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/hdftc_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-duplex frame timeout controller package
// Shared widths, command codes, register indexes and transfer structs.
// ----------------------------------------------------------------------------
package hdftc_pkg;

  // Width of the buffer and idle counters.
  localparam int COUNT_W = 16;
  // Width used to compare idle ticks against a 16-bit timeout.
  localparam int CMP_W   = (COUNT_W > 16) ? COUNT_W : 16;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_READ  = 2'd1,
    FN_WRITE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CFG_LINK_ENABLE = 2'd0,
    CFG_FIRST_BYTE  = 2'd1,
    CFG_GAP         = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic        link_enable;
    logic [15:0] first_byte_timeout;
    logic [15:0] gap_timeout;
  } cfg_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  rx_bytes;
    logic        tx_empty;
    logic [15:0] max_len;
  } item_t;

  typedef struct packed {
    logic [15:0] rx_len;
    logic        rx_ok;
    logic        rx_done;
    logic        tx_done;
    logic        accepted;
    logic        drive_enable;
    logic        busy_res;
    logic [1:0]  line_state;
  } res_t;

endpackage

// ===== hw/rtl/hdftc_core.sv =====
// ----------------------------------------------------------------------------
// Half-duplex frame timeout controller core
// Line state machine, buffer and idle counters; one item per cycle while fire is high.
// ----------------------------------------------------------------------------
`include "half_duplex_frame_timeout_ctrl_top_macros.svh"

module hdftc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  hdftc_pkg::item_t    item,
  input  hdftc_pkg::cfg_t     cfg,
  output hdftc_pkg::res_t     res
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_TX   = 2'd1,
    ST_WAIT = 2'd2,
    ST_RECV = 2'd3
  } line_state_t;

  localparam logic [hdftc_pkg::COUNT_W-1:0] CNT_MAX = '1;

  line_state_t                     state, state_next, state_eff;
  logic [hdftc_pkg::COUNT_W-1:0]   remaining, remaining_next;
  logic [hdftc_pkg::COUNT_W-1:0]   capacity, capacity_next;
  logic [hdftc_pkg::COUNT_W-1:0]   idle_ticks, idle_ticks_next;
  logic [hdftc_pkg::COUNT_W-1:0]   rx_inc, idle_inc, frame_len;
  logic [15:0]                     limit;
  logic                            accepted, tx_done, rx_done;

  always_comb begin
    state_next      = state;
    remaining_next  = remaining;
    capacity_next   = capacity;
    idle_ticks_next = idle_ticks;
    accepted        = 1'b0;
    tx_done         = 1'b0;
    rx_done         = 1'b0;
    state_eff       = cfg.link_enable ? state : ST_IDLE;
    rx_inc          = hdftc_pkg::COUNT_W'(item.rx_bytes);
    idle_inc        = (idle_ticks != CNT_MAX) ? idle_ticks + 1'b1 : idle_ticks;
    limit           = (state_eff == ST_WAIT) ? cfg.first_byte_timeout : cfg.gap_timeout;
    frame_len       = capacity - remaining;
    unique case (item.func)
      hdftc_pkg::FN_TICK: begin
        state_next = state_eff;
        unique case (state_eff)
          ST_TX: begin
            if (item.tx_empty) begin
              tx_done    = 1'b1;
              state_next = ST_IDLE;
            end
          end
          ST_WAIT, ST_RECV: begin
            if (item.rx_bytes != 8'd0) begin
              remaining_next  = (remaining > rx_inc) ? remaining - rx_inc : '0;
              idle_ticks_next = '0;
              state_next      = ST_RECV;
            end else begin
              idle_ticks_next = idle_inc;
              if (hdftc_pkg::CMP_W'(idle_inc) >= hdftc_pkg::CMP_W'(limit)) begin
                rx_done    = 1'b1;
                state_next = ST_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      hdftc_pkg::FN_READ: begin
        if (state == ST_IDLE) begin
          capacity_next   = hdftc_pkg::COUNT_W'(item.max_len);
          remaining_next  = hdftc_pkg::COUNT_W'(item.max_len);
          idle_ticks_next = '0;
          state_next      = ST_WAIT;
          accepted        = 1'b1;
        end
      end
      hdftc_pkg::FN_WRITE: begin
        if (state == ST_IDLE) begin
          state_next = ST_TX;
          accepted   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.line_state   = state_next;
    res.busy_res     = (state_next != ST_IDLE);
    res.drive_enable = (state_next == ST_TX);
    res.accepted     = accepted;
    res.tx_done      = tx_done;
    res.rx_done      = rx_done;
    res.rx_len       = rx_done ? 16'(frame_len) : 16'd0;
    res.rx_ok        = rx_done && (16'(frame_len) != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      remaining  <= '0;
      capacity   <= '0;
      idle_ticks <= '0;
    end else if (fire) begin
      state      <= state_next;
      remaining  <= remaining_next;
      capacity   <= capacity_next;
      idle_ticks <= idle_ticks_next;
    end
  end

  // A start is never taken unless the line was idle.
  `HDFTC_ASSERT_NOW(a_start_only_idle, clk, rst, fire && accepted, state == ST_IDLE)
  // Closing a frame always returns the line to idle.
  `HDFTC_ASSERT_NEXT(a_close_to_idle, clk, rst, fire && (rx_done || tx_done), state == ST_IDLE)
  // A freshly opened read has its whole buffer free.
  `HDFTC_ASSERT_NEXT(a_read_full_buf, clk, rst,
                     fire && accepted && (item.func == hdftc_pkg::FN_READ),
                     (remaining == capacity) && (idle_ticks == '0))
  // The free space never exceeds the loaded capacity.
  `HDFTC_ASSERT_NOW(a_rem_le_cap, clk, rst, 1'b1, remaining <= capacity)

endmodule

// ===== hw/rtl/half_duplex_frame_timeout_ctrl_top.sv =====
// ----------------------------------------------------------------------------
// Half-duplex frame timeout controller top level
// Input items and results are both registered. Throughput is one item per
// cycle while the result stream is not stalled by m_tready.
// Reset (rst, synchronous): line idle, counters zero, link disabled,
// first-byte timeout 1000 ticks, gap timeout 10 ticks.
// ----------------------------------------------------------------------------
module half_duplex_frame_timeout_ctrl_top (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // rx_bytes[7:0], tx_empty[8], max_len[24:9], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // line_state[1:0], busy_res[2], drive_enable[3],
                                 // accepted[4], tx_done[5], rx_done[6], rx_ok[7],
                                 // rx_len[23:8]
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  hdftc_pkg::cfg_t  cfg;
  hdftc_pkg::item_t item;
  hdftc_pkg::res_t  res, res_q;
  logic             in_valid, out_valid, out_free, fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_enable        <= 1'b0;
      cfg.first_byte_timeout <= 16'd1000;
      cfg.gap_timeout        <= 16'd10;
    end else if (cfg_valid) begin
      unique case (hdftc_pkg::cfg_index_t'(cfg_index))
        hdftc_pkg::CFG_LINK_ENABLE: cfg.link_enable        <= cfg_data[0];
        hdftc_pkg::CFG_FIRST_BYTE:  cfg.first_byte_timeout <= cfg_data;
        hdftc_pkg::CFG_GAP:         cfg.gap_timeout        <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register drains or is empty, so the held item can move on.
  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.func     <= hdftc_pkg::func_t'(s_tuser);
      item.rx_bytes <= s_tdata[7:0];
      item.tx_empty <= s_tdata[8];
      item.max_len  <= s_tdata[24:9];
    end
  end

  hdftc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = res_q;

endmodule

// ===== bench/hdftc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-duplex frame timeout controller bench package
// Line state codes and a scoreboard that tracks the controller's line state,
// predicts the response to every accepted command and checks the results.
// ----------------------------------------------------------------------------
package hdftc_tb_pkg;

  import hdftc_pkg::*;

  typedef enum logic [1:0] {
    LINE_IDLE = 2'd0,
    LINE_TX   = 2'd1,
    LINE_WAIT = 2'd2,
    LINE_RECV = 2'd3
  } line_t;

  class frame_scoreboard;
    // Register copies.
    logic        link_on;
    logic [15:0] first_limit;
    logic [15:0] gap_limit;
    // Controller state copies.
    line_t       cur_line;
    logic [15:0] space_left;
    logic [15:0] capacity;
    logic [15:0] quiet_ticks;

    res_t        line_responses_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned frames_closed;
    int unsigned sends_done;

    function new();
      link_on       = 1'b0;
      first_limit   = 16'd1000;
      gap_limit     = 16'd10;
      cur_line      = LINE_IDLE;
      space_left    = '0;
      capacity      = '0;
      quiet_ticks   = '0;
      mismatches    = 0;
      checked       = 0;
      frames_closed = 0;
      sends_done    = 0;
    endfunction

    function void apply_reg(cfg_index_t idx, logic [15:0] val);
      case (idx)
        CFG_LINK_ENABLE: link_on     = val[0];
        CFG_FIRST_BYTE:  first_limit = val;
        CFG_GAP:         gap_limit   = val;
        default: ;
      endcase
    endfunction

    function bit line_busy();
      return cur_line != LINE_IDLE;
    endfunction

    function int unsigned pending();
      return line_responses_due.size();
    endfunction

    function void predict_line_response(item_t cmd);
      res_t        r;
      logic [15:0] limit;
      r = '0;
      case (cmd.func)
        FN_TICK: begin
          if (!link_on) cur_line = LINE_IDLE;
          if (cur_line == LINE_TX) begin
            if (cmd.tx_empty) begin
              r.tx_done = 1'b1;
              cur_line  = LINE_IDLE;
              sends_done++;
            end
          end else if (cur_line == LINE_WAIT || cur_line == LINE_RECV) begin
            if (cmd.rx_bytes != 8'd0) begin
              // Free space runs down to zero and stays there.
              space_left  = (space_left > cmd.rx_bytes) ? space_left - cmd.rx_bytes : '0;
              quiet_ticks = '0;
              cur_line    = LINE_RECV;
            end else begin
              limit = (cur_line == LINE_WAIT) ? first_limit : gap_limit;
              if (quiet_ticks != '1) quiet_ticks = quiet_ticks + 16'd1;
              if (quiet_ticks >= limit) begin
                r.rx_len  = capacity - space_left;
                r.rx_done = 1'b1;
                r.rx_ok   = (r.rx_len != 16'd0);
                cur_line  = LINE_IDLE;
                frames_closed++;
              end
            end
          end
        end
        FN_READ: begin
          if (cur_line == LINE_IDLE) begin
            capacity    = cmd.max_len;
            space_left  = cmd.max_len;
            quiet_ticks = '0;
            cur_line    = LINE_WAIT;
            r.accepted  = 1'b1;
          end
        end
        FN_WRITE: begin
          if (cur_line == LINE_IDLE) begin
            cur_line   = LINE_TX;
            r.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      r.line_state   = cur_line;
      r.busy_res     = (cur_line != LINE_IDLE);
      r.drive_enable = (cur_line == LINE_TX);
      line_responses_due.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf("state=%0d busy=%0d drv=%0d acc=%0d txd=%0d rxd=%0d ok=%0d len=%0d",
                       r.line_state, r.busy_res, r.drive_enable, r.accepted, r.tx_done,
                       r.rx_done, r.rx_ok, r.rx_len);
    endfunction

    function void check_line_response(res_t got);
      res_t  exp;
      string bad;
      checked++;
      if (line_responses_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %s", checked, show(got));
        return;
      end
      exp = line_responses_due.pop_front();
      bad = "";
      if (got.line_state   !== exp.line_state)   bad = {bad, " line_state"};
      if (got.busy_res     !== exp.busy_res)     bad = {bad, " busy_res"};
      if (got.drive_enable !== exp.drive_enable) bad = {bad, " drive_enable"};
      if (got.accepted     !== exp.accepted)     bad = {bad, " accepted"};
      if (got.tx_done      !== exp.tx_done)      bad = {bad, " tx_done"};
      if (got.rx_done      !== exp.rx_done)      bad = {bad, " rx_done"};
      if (got.rx_ok        !== exp.rx_ok)        bad = {bad, " rx_ok"};
      if (got.rx_len       !== exp.rx_len)       bad = {bad, " rx_len"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch in%s", checked, bad);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_half_duplex_frame_timeout_ctrl_top.sv =====
// ----------------------------------------------------------------------------
// Half-duplex frame timeout controller testbench
// Drives start-read, start-write and tick commands through the input stream,
// predicts every line response in a scoreboard and checks the result stream.
// Runs a directed opening, then random transmit and receive sequences under
// several register settings and idle/stall mixes, with one long result stall.
// ----------------------------------------------------------------------------
module tb_half_duplex_frame_timeout_ctrl_top;

  import hdftc_pkg::*;
  import hdftc_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_LINK_ENABLE;
  logic [15:0] cfg_data  = '0;

  frame_scoreboard sb = new();

  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int unsigned hold_token   = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent   = 0;
  int unsigned phases_run   = 0;

  half_duplex_frame_timeout_ctrl_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Result side: checks each transfer and stalls at random or for a long hold.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_line_response(res_t'(m_tdata));
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", quiet_cycles);
      $display("tb_half_duplex_frame_timeout_ctrl_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t command(func_t f, logic [7:0] rx, logic txe, logic [15:0] len);
    item_t it;
    it.func     = f;
    it.rx_bytes = rx;
    it.tx_empty = txe;
    it.max_len  = len;
    return it;
  endfunction

  function automatic item_t stray_item();
    return command(func_t'(2'($urandom_range(3))), 8'($urandom), 1'($urandom), 16'($urandom));
  endfunction

  function automatic logic [7:0] arrival_bytes();
    if ($urandom_range(99) >= 35) return 8'd0;
    if ($urandom_range(3) == 0) return 8'($urandom_range(255, 1));
    return 8'($urandom_range(8, 1));
  endfunction

  function automatic logic [15:0] buffer_len();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(40));
    endcase
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, it.max_len, it.tx_empty, it.rx_bytes};
    s_tuser  <= it.func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_line_response(it);
    items_sent++;
  endtask

  // Writes all three registers in one burst; valid drops only after the last.
  task automatic write_regs(input logic le, input logic [15:0] fb, input logic [15:0] gap);
    cfg_index_t  idx;
    logic [15:0] val;
    for (int k = 0; k < 3; k++) begin
      idx = cfg_index_t'(k);
      if (idx == CFG_LINK_ENABLE) val = {15'($urandom), le};
      else if (idx == CFG_FIRST_BYTE) val = fb;
      else val = gap;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.apply_reg(idx, val);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed read and write sequences with random content, plus
  // stray commands that land on every state.
  task automatic run_traffic(input int unsigned count);
    int unsigned first;
    int unsigned ticks;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_item(command(FN_READ, 8'($urandom), 1'($urandom), buffer_len()));
        ticks = 0;
        while (sb.line_busy() && ticks < 80) begin
          if ($urandom_range(9) == 0) send_item(stray_item());
          else send_item(command(FN_TICK, arrival_bytes(), 1'($urandom), 16'($urandom)));
          ticks++;
        end
      end else if (pick < 75) begin
        send_item(command(FN_WRITE, 8'($urandom), 1'($urandom), 16'($urandom)));
        ticks = 0;
        while (sb.line_busy() && ticks < 20) begin
          if ($urandom_range(9) == 0) send_item(stray_item());
          else send_item(command(FN_TICK, 8'($urandom), $urandom_range(99) < 30,
                                 16'($urandom)));
          ticks++;
        end
      end else begin
        send_item(stray_item());
      end
    end
  endtask

  task automatic run_phase(input logic le, input logic [15:0] fb, input logic [15:0] gap,
                           input int idle, input int stall, input int unsigned count,
                           input bit hold);
    drain();
    write_regs(le, fb, gap);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_token <= hold_token + 1;
    run_traffic(count);
    phases_run++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: link disabled, so the tick after a start forces idle.
    send_item(command(FN_WRITE, 8'd0, 1'b0, 16'd0));
    send_item(command(FN_TICK, 8'd0, 1'b1, 16'd0));
    send_item(command(FN_READ, 8'd0, 1'b0, 16'd5));
    send_item(command(FN_WRITE, 8'd0, 1'b0, 16'd0));
    send_item(command(FN_TICK, 8'd3, 1'b0, 16'd0));

    drain();
    write_regs(1'b1, 16'd3, 16'd2);
    send_item(command(FN_TICK, 8'd0, 1'b0, 16'd0));
    send_item(command(func_t'(2'd3), 8'hFF, 1'b1, 16'hFFFF));
    send_item(command(FN_WRITE, 8'd0, 1'b0, 16'd0));
    // Starts while busy are refused.
    send_item(command(FN_WRITE, 8'd0, 1'b0, 16'd0));
    send_item(command(FN_READ, 8'd0, 1'b0, 16'd9));
    send_item(command(FN_TICK, 8'd0, 1'b0, 16'd0));
    send_item(command(FN_TICK, 8'd0, 1'b1, 16'd0));
    // Full-size buffer, largest arrivals, then the gap timeout closes the frame.
    send_item(command(FN_READ, 8'd0, 1'b0, 16'hFFFF));
    send_item(command(FN_TICK, 8'd0, 1'b0, 16'd0));
    send_item(command(FN_TICK, 8'hFF, 1'b0, 16'd0));
    send_item(command(FN_TICK, 8'hFF, 1'b1, 16'd0));
    send_item(command(FN_TICK, 8'd0, 1'b0, 16'd0));
    send_item(command(FN_TICK, 8'd0, 1'b0, 16'd0));
    // Empty buffer and no data: first-byte timeout with an empty frame.
    send_item(command(FN_READ, 8'd0, 1'b0, 16'd0));
    repeat (3) send_item(command(FN_TICK, 8'd0, 1'b0, 16'd0));
    // More bytes than space: free space stops at zero.
    send_item(command(FN_READ, 8'd0, 1'b0, 16'd3));
    send_item(command(FN_TICK, 8'hFF, 1'b0, 16'd0));
    repeat (2) send_item(command(FN_TICK, 8'd0, 1'b0, 16'd0));

    run_phase(1'b1, 16'd4,     16'd2,     0,  0,  150, 1'b0);
    run_phase(1'b1, 16'd0,     16'd0,     66, 0,  120, 1'b0);
    run_phase(1'b1, 16'd9,     16'd5,     0,  66, 150, 1'b0);
    run_phase(1'b1, 16'hFFFF,  16'hFFFF,  22, 22, 60,  1'b0);
    run_phase(1'b0, 16'd3,     16'd3,     0,  0,  60,  1'b0);
    run_phase(1'b1, 16'd30,    16'd7,     22, 22, 150, 1'b0);
    run_phase(1'b1, 16'd2,     16'd1,     0,  0,  200, 1'b1);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d commands over %0d phases, %0d results checked",
             items_sent, phases_run + 1, sb.checked);
    $display("%0d frames closed by timeout, %0d transmissions finished, %0d mismatches",
             sb.frames_closed, sb.sends_done, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_half_duplex_frame_timeout_ctrl_top passed");
    else
      $display("tb_half_duplex_frame_timeout_ctrl_top failed");
    $finish;
  end

endmodule
